/* rtl/core/fbab_pkg.sv */
// Shared types, constants and helper functions for the framebuffer alpha-blend write block.
`default_nettype none

package fbab_pkg;

    // Frame store geometry: the pixel index is always 16 bits wide.
    localparam int IDX_W       = 16;
    localparam int STORE_DEPTH = 1 << IDX_W;
    localparam int WORD_W      = 32;

    // Opaque alpha, also used for the blend complement.
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // One pixel write request.
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         src_red;
        logic [7:0]         src_green;
        logic [7:0]         src_blue;
        logic [7:0]         src_alpha;
    } fbab_in_t;

    // One result item.
    typedef struct packed {
        logic        written;
        logic [15:0] pixel_index;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic        frame_dirty;
    } fbab_out_t;

    // Write request into the frame store.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } fbab_wr_t;

    // Undivided blend sums for the three color channels.
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } fbab_sum_t;

    // Exact floor(v / 255) for any v up to 255*255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fbab_store.sv */
// Frame store memory with a post-reset clearing pass and a registered read port.
`default_nettype none

module fbab_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fbab_pkg::fbab_wr_t            wr,
    input  wire logic                          rd_en,
    input  wire logic [fbab_pkg::IDX_W-1:0]    rd_addr,
    output logic      [fbab_pkg::WORD_W-1:0]   rd_data,
    output logic                               busy
);
    import fbab_pkg::*;

    logic [WORD_W-1:0] mem_reg [0:STORE_DEPTH-1];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  clr_addr_reg;
    logic              clr_busy_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // The clearing pass owns the write port until every entry is zero.
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.addr;
            mem_wdata = wr.data;
        end
    end

    // Clearing pass sequencer: one entry per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {IDX_W{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

/* rtl/core/fbab_blend.sv */
// Per-channel source-over multiply-accumulate ahead of the divide by 255.
`default_nettype none

module fbab_blend (
    input  wire logic [7:0]                   src_red,
    input  wire logic [7:0]                   src_green,
    input  wire logic [7:0]                   src_blue,
    input  wire logic [7:0]                   alpha,
    input  wire logic [fbab_pkg::WORD_W-1:0]  dst_word,
    output fbab_pkg::fbab_sum_t               sums
);
    import fbab_pkg::*;

    logic [7:0] inv_alpha;

    assign inv_alpha = ALPHA_OPAQUE - alpha;

    // Each sum is src*a + dst*(255-a), at most 255*255, so 16 bits hold it.
    assign sums.red   = ({8'd0, src_red}   * {8'd0, alpha})
                      + ({8'd0, dst_word[7:0]}   * {8'd0, inv_alpha});
    assign sums.green = ({8'd0, src_green} * {8'd0, alpha})
                      + ({8'd0, dst_word[15:8]}  * {8'd0, inv_alpha});
    assign sums.blue  = ({8'd0, src_blue}  * {8'd0, alpha})
                      + ({8'd0, dst_word[23:16]} * {8'd0, inv_alpha});

endmodule

`default_nettype wire

/* rtl/core/framebuffer_alpha_blend_write.sv */
// Top level of the framebuffer alpha-blend pixel writer.
`default_nettype none

// Accepts one pixel write request per cycle while the result side is not stalled and no
// interlock holds the input, and returns one result per request, in order. Each request
// passes an input register, where the pixel index is formed and the frame store read is
// issued, then a multiply stage, a divide/write stage and an output register, around a
// single-port-write frame store of 65536 RGBA words. A request whose pixel index equals that
// of the request directly ahead of it waits in the input register, since that earlier blend
// has not yet been written back; all other back-to-back hazards are covered by forwarding the
// most recent write. After reset the block runs a clearing pass that zeroes all 65536 frame
// store entries, and accepts no request until it completes.
module framebuffer_alpha_blend_write #(
    parameter int SCREEN_W = 256,
    parameter int SCREEN_H = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_ready,
    input  wire fbab_pkg::fbab_in_t   pix,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output fbab_pkg::fbab_out_t       res
);
    import fbab_pkg::*;

    localparam logic [15:0] SCREEN_W_U = 16'(SCREEN_W);
    localparam logic [15:0] SCREEN_H_U = 16'(SCREEN_H);

    // Input stage.
    logic       a_valid_reg;
    fbab_in_t   a_reg;

    // Read stage results.
    logic             a_inb;
    logic [IDX_W-1:0] a_idx;
    logic [15:0]      a_row_base;
    logic [7:0]       a_alpha;
    logic             hazard;
    logic             adv;
    logic             a_move;
    logic             pix_accept;

    // Multiply stage.
    logic             b_valid_reg;
    logic             b_inb_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic [7:0]       b_red_reg;
    logic [7:0]       b_green_reg;
    logic [7:0]       b_blue_reg;
    logic [7:0]       b_alpha_reg;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] b_dst;
    fbab_sum_t        b_sums;

    // Divide and write stage.
    logic             c_valid_reg;
    logic             c_inb_reg;
    logic [IDX_W-1:0] c_idx_reg;
    logic [7:0]       c_alpha_reg;
    fbab_sum_t        c_sums_reg;
    logic [7:0]       c_red;
    logic [7:0]       c_green;
    logic [7:0]       c_blue;
    fbab_wr_t         wr;

    // Last write, for forwarding.
    logic              fw_valid_reg;
    logic [IDX_W-1:0]  fw_idx_reg;
    logic [WORD_W-1:0] fw_data_reg;

    logic       dirty_reg;
    logic       res_valid_reg;
    fbab_out_t  res_reg;
    logic       clr_busy;

    // Pipeline advances whenever the output register is free or being drained.
    assign adv = !res_valid_reg || res_ready;

    // Clip test and pixel index from the registered request.
    assign a_inb = !a_reg.pos_x[15] && !a_reg.pos_y[15]
                && (a_reg.pos_x < SCREEN_W_U) && (a_reg.pos_y < SCREEN_H_U);
    assign a_row_base = a_reg.pos_y * SCREEN_W_U;
    assign a_idx      = a_row_base + a_reg.pos_x;
    assign a_alpha    = (a_reg.src_alpha == 8'd0) ? ALPHA_OPAQUE : a_reg.src_alpha;

    // Read-after-write interlock against the request one stage ahead.
    assign hazard = a_valid_reg && a_inb && b_valid_reg && b_inb_reg && (a_idx == b_idx_reg);
    assign a_move = a_valid_reg && adv && !hazard;

    assign pix_ready  = !clr_busy && (!a_valid_reg || (adv && !hazard));
    assign pix_accept = pix_valid && pix_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            a_reg <= pix;
        end
    end

    fbab_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (a_move && a_inb),
        .rd_addr (a_idx),
        .rd_data (rd_data),
        .busy    (clr_busy)
    );

    // Multiply stage registers; an interlocked cycle inserts a bubble.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_move;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_inb_reg   <= a_inb;
            b_idx_reg   <= a_idx;
            b_red_reg   <= a_reg.src_red;
            b_green_reg <= a_reg.src_green;
            b_blue_reg  <= a_reg.src_blue;
            b_alpha_reg <= a_alpha;
        end
    end

    // Destination word, taking the most recent write when it hit the same entry.
    assign b_dst = (fw_valid_reg && (fw_idx_reg == b_idx_reg)) ? fw_data_reg : rd_data;

    fbab_blend u_blend (
        .src_red   (b_red_reg),
        .src_green (b_green_reg),
        .src_blue  (b_blue_reg),
        .alpha     (b_alpha_reg),
        .dst_word  (b_dst),
        .sums      (b_sums)
    );

    // Divide and write stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg)
        begin
            c_inb_reg   <= b_inb_reg;
            c_idx_reg   <= b_idx_reg;
            c_alpha_reg <= b_alpha_reg;
            c_sums_reg  <= b_sums;
        end
    end

    assign c_red   = div255(c_sums_reg.red);
    assign c_green = div255(c_sums_reg.green);
    assign c_blue  = div255(c_sums_reg.blue);

    // Write back the blended word as the request leaves the pipeline.
    assign wr.en   = adv && c_valid_reg && c_inb_reg;
    assign wr.addr = c_idx_reg;
    assign wr.data = {c_alpha_reg, c_blue, c_green, c_red};

    // Forwarding register and sticky dirty flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
            dirty_reg    <= 1'b0;
        end
        else if (wr.en)
        begin
            fw_valid_reg <= 1'b1;
            dirty_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fw_idx_reg  <= wr.addr;
            fw_data_reg <= wr.data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            if (c_inb_reg)
            begin
                res_reg.written     <= 1'b1;
                res_reg.pixel_index <= c_idx_reg;
                res_reg.out_red     <= c_red;
                res_reg.out_green   <= c_green;
                res_reg.out_blue    <= c_blue;
                res_reg.out_alpha   <= c_alpha_reg;
                res_reg.frame_dirty <= 1'b1;
            end
            else
            begin
                res_reg.written     <= 1'b0;
                res_reg.pixel_index <= '0;
                res_reg.out_red     <= '0;
                res_reg.out_green   <= '0;
                res_reg.out_blue    <= '0;
                res_reg.out_alpha   <= '0;
                res_reg.frame_dirty <= dirty_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The interlock keeps two in-flight writes to one entry from sitting in adjacent stages.
    a_no_adjacent_same_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_inb_reg && c_valid_reg && c_inb_reg) |-> (b_idx_reg != c_idx_reg))
        else $error("two writes to one entry in adjacent stages");

    // The dirty flag never clears once set.
    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |=> dirty_reg)
        else $error("dirty flag cleared");

    // A written pixel always carries an effective alpha, never zero.
    a_written_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.written) |-> (res_reg.out_alpha != 8'd0))
        else $error("written pixel with zero alpha");

endmodule

`default_nettype wire

/* sim/framebuffer_alpha_blend_write_tb.sv */
// Self-checking testbench for the framebuffer alpha-blend pixel writer.
module framebuffer_alpha_blend_write_tb;

    import fbab_pkg::*;

    localparam int SCR_W        = 256;
    localparam int SCR_H        = 256;
    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 64;
    localparam int TAIL_CYCLES  = 8;

    // One row of the directed table: a request and, where obvious, its result.
    typedef struct {
        fbab_in_t  req;
        bit        typed;
        fbab_out_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      pix_valid;
    logic      pix_ready;
    fbab_in_t  pix;
    logic      res_valid;
    logic      res_ready;
    fbab_out_t res;

    // Shadow copy of the frame store and the dirty flag.
    logic [31:0] shadow_store [0:STORE_DEPTH-1];
    logic        shadow_dirty;

    fbab_out_t   pending_results [$];
    dir_row_t    dir_rows [$];

    int          errors;
    int          checked;
    int          sent;
    int          clipped;
    int          same_pixel_pairs;
    int          prev_idx;
    int          cycle_count = 0;
    bit          hold_req;
    bit          no_idle;

    framebuffer_alpha_blend_write #(
        .SCREEN_W (SCR_W),
        .SCREEN_H (SCR_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic fbab_in_t px(input int x, input int y, input int r, input int g,
                                    input int b, input int a);
        fbab_in_t p;
        p.pos_x     = x[15:0];
        p.pos_y     = y[15:0];
        p.src_red   = r[7:0];
        p.src_green = g[7:0];
        p.src_blue  = b[7:0];
        p.src_alpha = a[7:0];
        return p;
    endfunction

    // Result of an opaque write, which stores the source color unchanged.
    function automatic fbab_out_t opaque_result(input int idx, input int r, input int g,
                                                input int b);
        fbab_out_t o;
        o.written     = 1'b1;
        o.pixel_index = idx[15:0];
        o.out_red     = r[7:0];
        o.out_green   = g[7:0];
        o.out_blue    = b[7:0];
        o.out_alpha   = ALPHA_OPAQUE;
        o.frame_dirty = 1'b1;
        return o;
    endfunction

    function automatic fbab_out_t clip_result(input bit dirty);
        fbab_out_t o;
        o             = '0;
        o.frame_dirty = dirty;
        return o;
    endfunction

    function automatic logic [7:0] mix(input int unsigned s, input int unsigned d,
                                       input int unsigned a);
        int unsigned v;
        v = (s * a + d * (255 - a)) / 255;
        return v[7:0];
    endfunction

    // Computes the result of one pixel write and updates the shadow store.
    function automatic fbab_out_t blend_pixel(input fbab_in_t p);
        fbab_out_t   o;
        int          x;
        int          y;
        int unsigned a;
        int unsigned idx;
        logic [31:0] old;
        x = $signed(p.pos_x);
        y = $signed(p.pos_y);
        o = '0;
        if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H)
        begin
            o.frame_dirty = shadow_dirty;
            clipped++;
            prev_idx = -1;
            return o;
        end
        a   = (p.src_alpha == 8'd0) ? 255 : p.src_alpha;
        idx = (y * SCR_W + x) & 32'hFFFF;
        old = shadow_store[idx];
        o.written     = 1'b1;
        o.pixel_index = idx[15:0];
        o.out_red     = mix(p.src_red, old[7:0], a);
        o.out_green   = mix(p.src_green, old[15:8], a);
        o.out_blue    = mix(p.src_blue, old[23:16], a);
        o.out_alpha   = a[7:0];
        o.frame_dirty = 1'b1;
        shadow_store[idx] = {o.out_alpha, o.out_blue, o.out_green, o.out_red};
        shadow_dirty      = 1'b1;
        if (prev_idx == int'(idx))
            same_pixel_pairs++;
        prev_idx = idx;
        return o;
    endfunction

    // Random request: hot pixels for read-after-write hazards, the whole screen,
    // the screen border, and the full coordinate range.
    function automatic fbab_in_t random_pixel();
        fbab_in_t p;
        int       pick;
        int       border [4];
        border = '{-1, 0, SCR_W - 1, SCR_W};
        pick   = $urandom_range(0, 9);
        p.src_red   = 8'($urandom_range(0, 255));
        p.src_green = 8'($urandom_range(0, 255));
        p.src_blue  = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       p.src_alpha = 8'd0;
            1:       p.src_alpha = ALPHA_OPAQUE;
            2:       p.src_alpha = 8'd1;
            default: p.src_alpha = 8'($urandom_range(0, 255));
        endcase
        if (pick <= 2)
        begin
            p.pos_x = $urandom_range(0, 1) ? 16'd255 : 16'd1;
            p.pos_y = $urandom_range(0, 1) ? 16'd0 : 16'd7;
        end
        else if (pick <= 6)
        begin
            p.pos_x = 16'($urandom_range(0, SCR_W - 1));
            p.pos_y = 16'($urandom_range(0, SCR_H - 1));
        end
        else if (pick == 7)
        begin
            p.pos_x = 16'(border[$urandom_range(0, 3)]);
            p.pos_y = 16'(border[$urandom_range(0, 3)]);
        end
        else
        begin
            p.pos_x = 16'($urandom_range(0, 16'hFFFF));
            p.pos_y = 16'($urandom_range(0, 16'hFFFF));
        end
        return p;
    endfunction

    function automatic int idle_gap();
        if (no_idle || hold_req)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 8);
        return 0;
    endfunction

    // Offers one request and records its expected result once it is accepted.
    task automatic send_pixel(input fbab_in_t p, input bit typed, input fbab_out_t want);
        fbab_out_t predicted;
        int        gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pix_ready);
        predicted = blend_pixel(p);
        pending_results.push_back(typed ? want : predicted);
        sent++;
    endtask

    // Stops offering requests until every outstanding result has come back.
    task automatic drain();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        fbab_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %h", $time, res);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("written", want.written, res.written);
                check_field("pixel_index", want.pixel_index, res.pixel_index);
                check_field("out_red", want.out_red, res.out_red);
                check_field("out_green", want.out_green, res.out_green);
                check_field("out_blue", want.out_blue, res.out_blue);
                check_field("out_alpha", want.out_alpha, res.out_alpha);
                check_field("frame_dirty", want.frame_dirty, res.frame_dirty);
                checked++;
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (no_idle)
            begin
                res_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Request side and run control.
    initial
    begin
        fbab_out_t none;
        rst_n            <= 1'b0;
        pix_valid        <= 1'b0;
        pix              <= '0;
        none             = '0;
        errors           = 0;
        checked          = 0;
        sent             = 0;
        clipped          = 0;
        same_pixel_pairs = 0;
        prev_idx         = -1;
        hold_req         = 1'b0;
        no_idle          = 1'b0;
        shadow_dirty     = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = '0;

        // Directed table: clipping on every side, screen corners, zero alpha,
        // partial blends and repeated writes to one pixel.
        dir_rows.push_back('{px(-1, 0, 9, 9, 9, 9), 1'b1, clip_result(1'b0)});
        dir_rows.push_back('{px(-32768, -32768, 255, 255, 255, 255), 1'b1, clip_result(1'b0)});
        dir_rows.push_back('{px(256, 0, 1, 2, 3, 4), 1'b1, clip_result(1'b0)});
        dir_rows.push_back('{px(0, 256, 1, 2, 3, 0), 1'b1, clip_result(1'b0)});
        dir_rows.push_back('{px(32767, 32767, 255, 0, 255, 0), 1'b1, clip_result(1'b0)});
        dir_rows.push_back('{px(0, 0, 255, 255, 255, 255), 1'b1,
                             opaque_result(0, 255, 255, 255)});
        dir_rows.push_back('{px(255, 255, 0, 0, 0, 255), 1'b1, opaque_result(65535, 0, 0, 0)});
        dir_rows.push_back('{px(255, 0, 12, 34, 56, 0), 1'b1, opaque_result(255, 12, 34, 56)});
        dir_rows.push_back('{px(0, 255, 200, 100, 50, 0), 1'b1,
                             opaque_result(65280, 200, 100, 50)});
        dir_rows.push_back('{px(-1, 255, 7, 7, 7, 7), 1'b1, clip_result(1'b1)});
        dir_rows.push_back('{px(0, 0, 0, 0, 0, 128), 1'b0, none});
        dir_rows.push_back('{px(0, 0, 255, 0, 255, 1), 1'b0, none});
        dir_rows.push_back('{px(0, 0, 10, 20, 30, 254), 1'b0, none});
        dir_rows.push_back('{px(1, 0, 255, 255, 255, 128), 1'b0, none});
        dir_rows.push_back('{px(0, 0, 90, 180, 45, 100), 1'b0, none});
        dir_rows.push_back('{px(255, 255, 255, 255, 255, 127), 1'b0, none});
        dir_rows.push_back('{px(256, 255, 1, 1, 1, 1), 1'b1, clip_result(1'b1)});
        dir_rows.push_back('{px(255, 256, 1, 1, 1, 1), 1'b1, clip_result(1'b1)});
        dir_rows.push_back('{px(128, 64, 255, 255, 255, 255), 1'b1,
                             opaque_result(16512, 255, 255, 255)});
        dir_rows.push_back('{px(128, 64, 0, 0, 0, 1), 1'b0, none});
        dir_rows.push_back('{px(128, 64, 170, 85, 15, 200), 1'b0, none});
        dir_rows.push_back('{px(-32768, 100, 3, 3, 3, 3), 1'b1, clip_result(1'b1)});
        dir_rows.push_back('{px(100, 32767, 3, 3, 3, 3), 1'b1, clip_result(1'b1)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_pixel(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Random traffic with idling on both sides.
        repeat (150)
            send_pixel(random_pixel(), 1'b0, none);

        // Long hold-off on the result side while requests keep coming.
        hold_req = 1'b1;
        repeat (30)
            send_pixel(random_pixel(), 1'b0, none);
        drain();

        repeat (150)
            send_pixel(random_pixel(), 1'b0, none);

        // Closing stretch at full rate on both sides.
        no_idle = 1'b1;
        repeat (60)
            send_pixel(random_pixel(), 1'b0, none);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d pixel writes (%0d clipped), %0d results checked.",
                 sent, clipped, checked);
        $display("Back-to-back writes to the same pixel: %0d; mismatches: %0d.",
                 same_pixel_pairs, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/fbab_pkg.sv
rtl/core/fbab_store.sv
rtl/core/fbab_blend.sv
rtl/core/framebuffer_alpha_blend_write.sv
sim/framebuffer_alpha_blend_write_tb.sv
